@@ rtl/core/sem_pkg.sv @@
// ----------------------------------------------------------------------------
// sem_pkg
// Shared constants and types of the RGB Sobel edge magnitude block.
// ----------------------------------------------------------------------------
package sem_pkg;

    localparam int SEM_MAX_WIDTH  = 1024;
    localparam int SEM_MAX_HEIGHT = 4096;

    localparam int SEM_PIX_W   = 24;
    localparam int SEM_CH_W    = 8;
    localparam int SEM_CFG_W   = 13;
    localparam int SEM_FW_W    = 11;
    localparam int SEM_FH_W    = 13;
    localparam int SEM_SQ_W    = 21;
    localparam int SEM_GRAD_W  = 10;
    localparam int SEM_ROOT_STEPS = 11;
    localparam int SEM_STEP_W  = 4;
    localparam int SEM_TAPS    = 9;
    localparam int SEM_TAP_W   = 4;

    localparam logic [SEM_FW_W-1:0] SEM_FW_RESET = 11'd640;
    localparam logic [SEM_FH_W-1:0] SEM_FH_RESET = 13'd480;

    localparam logic REG_FRAME_WIDTH  = 1'b0;
    localparam logic REG_FRAME_HEIGHT = 1'b1;

    localparam logic OP_PIXEL = 1'b0;

    typedef struct packed {
        logic start;
        logic take;
    } lane_ctrl_t;

    typedef struct packed {
        logic valid;
    } lane_stat_t;

endpackage

@@ rtl/core/sem_ram.sv @@
// ----------------------------------------------------------------------------
// sem_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module sem_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 3072
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

@@ rtl/core/sem_lane.sv @@
// ----------------------------------------------------------------------------
// sem_lane
// One color channel: Sobel gradients, sum of squares, bitwise square root.
// ----------------------------------------------------------------------------
module sem_lane (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  sem_pkg::lane_ctrl_t    ctrl,
    input  logic [7:0]             pix [sem_pkg::SEM_TAPS],
    output sem_pkg::lane_stat_t    stat,
    output logic [7:0]             mag
);

    typedef enum logic [1:0] {L_IDLE, L_SQUARE, L_ROOT, L_DONE} lane_state_t;

    localparam int GW = sem_pkg::SEM_GRAD_W;
    localparam int QW = sem_pkg::SEM_SQ_W;

    lane_state_t                   state_reg;
    logic [GW-1:0]                 ax_reg, ay_reg;
    logic [QW-1:0]                 x_reg, res_reg, bit_reg;
    logic [sem_pkg::SEM_STEP_W-1:0] step_reg;

    logic [GW-1:0] px_pos, px_neg, py_pos, py_neg, ax, ay;
    logic [QW:0]   trial;
    logic [QW-1:0] rnd;

    always_comb begin
        px_pos = GW'(pix[2]) + (GW'(pix[5]) << 1) + GW'(pix[8]);
        px_neg = GW'(pix[0]) + (GW'(pix[3]) << 1) + GW'(pix[6]);
        py_pos = GW'(pix[6]) + (GW'(pix[7]) << 1) + GW'(pix[8]);
        py_neg = GW'(pix[0]) + (GW'(pix[1]) << 1) + GW'(pix[2]);
        ax = (px_pos >= px_neg) ? px_pos - px_neg : px_neg - px_pos;
        ay = (py_pos >= py_neg) ? py_pos - py_neg : py_neg - py_pos;
        trial = {1'b0, res_reg} + {1'b0, bit_reg};
        // round up when the remainder exceeds the root
        rnd = (x_reg > res_reg) ? res_reg + QW'(1) : res_reg;
        mag = (rnd > QW'(255)) ? 8'd255 : rnd[7:0];
        stat.valid = (state_reg == L_DONE);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= L_IDLE;
        end else begin
            unique case (state_reg)
                L_IDLE: begin
                    if (ctrl.start) begin
                        ax_reg    <= ax;
                        ay_reg    <= ay;
                        state_reg <= L_SQUARE;
                    end
                end
                L_SQUARE: begin
                    x_reg     <= QW'(ax_reg * ax_reg) + QW'(ay_reg * ay_reg);
                    res_reg   <= '0;
                    bit_reg   <= QW'(1) << (QW - 1);
                    step_reg  <= '0;
                    state_reg <= L_ROOT;
                end
                L_ROOT: begin
                    if ({1'b0, x_reg} >= trial) begin
                        x_reg   <= x_reg - trial[QW-1:0];
                        res_reg <= (res_reg >> 1) + bit_reg;
                    end else begin
                        res_reg <= res_reg >> 1;
                    end
                    bit_reg  <= bit_reg >> 2;
                    step_reg <= step_reg + 1'b1;
                    if (step_reg == sem_pkg::SEM_STEP_W'(sem_pkg::SEM_ROOT_STEPS - 1)) begin
                        state_reg <= L_DONE;
                    end
                end
                L_DONE: begin
                    if (ctrl.take) begin
                        state_reg <= L_IDLE;
                    end
                end
                default: state_reg <= L_IDLE;
            endcase
        end
    end

endmodule

@@ rtl/core/sobel_edge_magnitude_rgb.sv @@
// ----------------------------------------------------------------------------
// sobel_edge_magnitude_rgb
// Streaming 3x3 Sobel edge magnitude over RGB pixels, one lane per channel.
// ----------------------------------------------------------------------------
//
//  channel  dir  ports                                   role
//  s_       in   s_op, s_red_in, s_green_in, s_blue_in   pixel or flush request
//  m_       out  m_red_edge .. m_blue_edge, m_frame_end  edge result request
//  cfg_     in   cfg_index, cfg_data                     register write
//
// A pixel that yields no result is written to the line store as it is
// accepted, and the next request is taken right after. A request that yields
// a result is worked through in turn up to the next request: the nine reads
// of the three-row line store through its single read port, the lane start,
// the squaring, the 11-step square root and the merge. Reset brings the
// registers to 640 x 480 and the frame position to zero; the line store needs
// no clearing. A stalled result waits in the output register while the next
// request is already worked on; only the final merge waits for it.
//
module sobel_edge_magnitude_rgb #(
    parameter int MAX_WIDTH  = sem_pkg::SEM_MAX_WIDTH,
    parameter int MAX_HEIGHT = sem_pkg::SEM_MAX_HEIGHT
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic                          s_op,
    input  logic [7:0]                    s_red_in,
    input  logic [7:0]                    s_green_in,
    input  logic [7:0]                    s_blue_in,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [7:0]                    m_red_edge,
    output logic [7:0]                    m_green_edge,
    output logic [7:0]                    m_blue_edge,
    output logic                          m_frame_end,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic                          cfg_index,
    input  logic [sem_pkg::SEM_CFG_W-1:0] cfg_data
);

    typedef enum logic [1:0] {S_IDLE, S_READ, S_CALC} state_t;

    localparam int DEPTH = 3 * MAX_WIDTH;
    localparam int AW    = $clog2(DEPTH);
    localparam int XW    = $clog2(MAX_WIDTH);
    localparam int WW    = $clog2(MAX_WIDTH + 1);
    localparam int HW    = $clog2(MAX_HEIGHT + 1);
    localparam int LW    = $clog2(MAX_WIDTH + 3);
    localparam int PW    = sem_pkg::SEM_PIX_W;
    localparam int NT    = sem_pkg::SEM_TAPS;
    localparam int TW    = sem_pkg::SEM_TAP_W;

    state_t                         state_reg;
    logic [sem_pkg::SEM_FW_W-1:0]   fw_reg;
    logic [sem_pkg::SEM_FH_W-1:0]   fh_reg;
    logic [XW-1:0]                  in_col_reg, out_col_reg;
    logic [HW-1:0]                  in_row_reg, out_row_reg;
    logic [1:0]                     in_slot_reg, out_slot_reg;
    logic [LW-1:0]                  lead_reg;
    logic [TW-1:0]                  rd_k_reg;
    logic                           rd_ok_reg, rd_sub_reg;
    logic                           from_pix_reg, start_reg;
    logic [PW-1:0]                  pix_reg;
    logic [AW-1:0]                  wr_addr_reg;
    logic [PW-1:0]                  window_reg [NT];
    logic                           m_valid_reg, m_end_reg;
    logic [7:0]                     m_red_reg, m_green_reg, m_blue_reg;

    logic [WW-1:0]  w_eff;
    logic [HW-1:0]  h_eff;
    logic           full, store, emit, accept, take, lanes_done, last_out;
    logic [AW-1:0]  wr_addr_now, rd_addr, ram_waddr;
    logic [PW-1:0]  s_pix, ram_wdata, ram_rdata;
    logic           ram_we;
    logic [1:0]     dr, dc, rd_slot, prev_slot, next_slot, in_next_slot;
    logic [XW-1:0]  rd_col;
    logic           rd_ok;

    sem_pkg::lane_ctrl_t lane_ctrl;
    sem_pkg::lane_stat_t lane_stat [3];
    logic [7:0]          lane_mag  [3];
    logic [7:0]          lane_pix  [3][NT];

    function automatic logic [AW-1:0] slot_addr(input logic [1:0] slot,
                                                input logic [XW-1:0] col);
        logic [AW-1:0] base;
        case (slot)
            2'd1:    base = AW'(MAX_WIDTH);
            2'd2:    base = AW'(2 * MAX_WIDTH);
            default: base = '0;
        endcase
        return base + AW'(col);
    endfunction

    // Clamp the frame size registers to the supported range.
    always_comb begin
        if (fw_reg == '0) begin
            w_eff = WW'(1);
        end else if (32'(fw_reg) > MAX_WIDTH) begin
            w_eff = WW'(MAX_WIDTH);
        end else begin
            w_eff = WW'(fw_reg);
        end
        if (fh_reg == '0) begin
            h_eff = HW'(1);
        end else if (32'(fh_reg) > MAX_HEIGHT) begin
            h_eff = HW'(MAX_HEIGHT);
        end else begin
            h_eff = HW'(fh_reg);
        end
    end

    assign s_pix = {s_red_in, s_green_in, s_blue_in};

    // Frame is complete once the input row counter has reached the height;
    // a pixel then counts as a flush. A pixel yields a result once the lower
    // right neighbor of the oldest pending pixel is the one arriving.
    always_comb begin
        full   = (in_row_reg == h_eff);
        store  = (s_op == sem_pkg::OP_PIXEL) && !full;
        emit   = store ? (lead_reg > LW'(w_eff)) : full;
        accept = (state_reg == S_IDLE) && s_valid;
        s_ready   = (state_reg == S_IDLE);
        cfg_ready = 1'b1;
        in_next_slot = (in_slot_reg == 2'd2) ? 2'd0 : in_slot_reg + 2'd1;
        prev_slot    = (out_slot_reg == 2'd0) ? 2'd2 : out_slot_reg - 2'd1;
        next_slot    = (out_slot_reg == 2'd2) ? 2'd0 : out_slot_reg + 2'd1;
        wr_addr_now  = slot_addr(in_slot_reg, in_col_reg);
        last_out = (WW'(out_col_reg) + WW'(1) == w_eff) &&
                   (out_row_reg + HW'(1) == h_eff);
    end

    // Tap k of the window sits at row offset k / 3 and column offset k % 3.
    always_comb begin
        case (rd_k_reg)
            4'd0, 4'd1, 4'd2: dr = 2'd0;
            4'd3, 4'd4, 4'd5: dr = 2'd1;
            default:          dr = 2'd2;
        endcase
        case (rd_k_reg)
            4'd0, 4'd3, 4'd6: dc = 2'd0;
            4'd1, 4'd4, 4'd7: dc = 2'd1;
            default:          dc = 2'd2;
        endcase
        rd_slot = (dr == 2'd0) ? prev_slot : (dr == 2'd1) ? out_slot_reg : next_slot;
        rd_col  = (dc == 2'd0) ? out_col_reg - XW'(1) :
                  (dc == 2'd1) ? out_col_reg : out_col_reg + XW'(1);
        rd_ok = !((dr == 2'd0) && (out_row_reg == '0)) &&
                !((dr == 2'd2) && (out_row_reg + HW'(1) == h_eff)) &&
                !((dc == 2'd0) && (out_col_reg == '0)) &&
                !((dc == 2'd2) && (WW'(out_col_reg) + WW'(1) == w_eff));
        rd_addr = slot_addr(rd_slot, rd_col);
    end

    // Store a pixel at once when it yields nothing; otherwise hold it until
    // the window has been read, since it may overwrite a tap still needed.
    always_comb begin
        if (state_reg == S_IDLE) begin
            ram_we    = accept && store && !emit;
            ram_waddr = wr_addr_now;
            ram_wdata = s_pix;
        end else begin
            ram_we    = (state_reg == S_READ) && (rd_k_reg == TW'(NT)) && from_pix_reg;
            ram_waddr = wr_addr_reg;
            ram_wdata = pix_reg;
        end
    end

    sem_ram #(
        .WIDTH (PW),
        .DEPTH (DEPTH)
    ) u_line_store (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (rd_addr),
        .rdata (ram_rdata)
    );

    // Merge: all three lanes finish together; hand the result over when the
    // output register is free or being drained.
    always_comb begin
        lanes_done = lane_stat[0].valid && lane_stat[1].valid && lane_stat[2].valid;
        take = (state_reg == S_CALC) && lanes_done && (!m_valid_reg || m_ready);
        lane_ctrl.start = start_reg;
        lane_ctrl.take  = take;
    end

    for (genvar ch = 0; ch < 3; ch++) begin : g_lane
        for (genvar k = 0; k < NT; k++) begin : g_tap
            assign lane_pix[ch][k] = window_reg[k][PW-1-8*ch -: 8];
        end
        sem_lane u_lane (
            .aclk    (aclk),
            .aresetn (aresetn),
            .ctrl    (lane_ctrl),
            .pix     (lane_pix[ch]),
            .stat    (lane_stat[ch]),
            .mag     (lane_mag[ch])
        );
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            fw_reg       <= sem_pkg::SEM_FW_RESET;
            fh_reg       <= sem_pkg::SEM_FH_RESET;
            in_col_reg   <= '0;
            in_row_reg   <= '0;
            in_slot_reg  <= '0;
            out_col_reg  <= '0;
            out_row_reg  <= '0;
            out_slot_reg <= '0;
            lead_reg     <= '0;
            rd_k_reg     <= '0;
            start_reg    <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            start_reg <= 1'b0;
            if (m_valid_reg && m_ready) begin
                m_valid_reg <= 1'b0;
            end

            // Register write: take the value and restart the frame.
            if (cfg_valid) begin
                unique case (cfg_index)
                    sem_pkg::REG_FRAME_WIDTH:  fw_reg <= cfg_data[sem_pkg::SEM_FW_W-1:0];
                    sem_pkg::REG_FRAME_HEIGHT: fh_reg <= cfg_data;
                    default: ;
                endcase
                in_col_reg   <= '0;
                in_row_reg   <= '0;
                in_slot_reg  <= '0;
                out_col_reg  <= '0;
                out_row_reg  <= '0;
                out_slot_reg <= '0;
                lead_reg     <= '0;
            end

            unique case (state_reg)
                S_IDLE: begin
                    if (accept) begin
                        if (store) begin
                            // advance the input position
                            if (WW'(in_col_reg) + WW'(1) >= w_eff) begin
                                in_col_reg  <= '0;
                                in_row_reg  <= in_row_reg + HW'(1);
                                in_slot_reg <= in_next_slot;
                            end else begin
                                in_col_reg <= in_col_reg + XW'(1);
                            end
                        end
                        if (emit) begin
                            pix_reg      <= s_pix;
                            from_pix_reg <= store;
                            wr_addr_reg  <= wr_addr_now;
                            rd_k_reg     <= '0;
                            state_reg    <= S_READ;
                            if (!store) begin
                                lead_reg <= lead_reg - LW'(1);
                            end
                        end else if (store) begin
                            lead_reg <= lead_reg + LW'(1);
                        end
                    end
                end
                S_READ: begin
                    // issue tap k, capture tap k-1 from the registered read
                    rd_ok_reg  <= rd_ok;
                    rd_sub_reg <= from_pix_reg && (rd_k_reg == TW'(NT - 1));
                    if (rd_k_reg != '0) begin
                        window_reg[rd_k_reg - TW'(1)] <= !rd_ok_reg ? '0 :
                                                         rd_sub_reg ? pix_reg : ram_rdata;
                    end
                    if (rd_k_reg == TW'(NT)) begin
                        start_reg <= 1'b1;
                        state_reg <= S_CALC;
                    end else begin
                        rd_k_reg <= rd_k_reg + TW'(1);
                    end
                end
                S_CALC: begin
                    if (take) begin
                        m_valid_reg <= 1'b1;
                        m_red_reg   <= lane_mag[0];
                        m_green_reg <= lane_mag[1];
                        m_blue_reg  <= lane_mag[2];
                        m_end_reg   <= last_out;
                        state_reg   <= S_IDLE;
                        if (last_out) begin
                            // frame done: restart all positions
                            in_col_reg   <= '0;
                            in_row_reg   <= '0;
                            in_slot_reg  <= '0;
                            out_col_reg  <= '0;
                            out_row_reg  <= '0;
                            out_slot_reg <= '0;
                            lead_reg     <= '0;
                        end else if (WW'(out_col_reg) + WW'(1) == w_eff) begin
                            out_col_reg  <= '0;
                            out_row_reg  <= out_row_reg + HW'(1);
                            out_slot_reg <= next_slot;
                        end else begin
                            out_col_reg <= out_col_reg + XW'(1);
                        end
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_red_edge   = m_red_reg;
    assign m_green_edge = m_green_reg;
    assign m_blue_edge  = m_blue_reg;
    assign m_frame_end  = m_end_reg;

endmodule
